// ===== rtl/frame_check_code_engine_macros.svh =====
// Assertion macros for the frame check code engine.
// Used by the top level only; no other dependencies.
`ifndef FRAME_CHECK_CODE_ENGINE_MACROS_SVH
`define FRAME_CHECK_CODE_ENGINE_MACROS_SVH

// Checked while out of reset.
`define FCCE_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define FCCE_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fcce_pkg.sv =====
// Shared types, codes and the CRC byte update for the frame check code engine.
// No dependencies.
`default_nettype none

package fcce_pkg;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] BYTE_MASK = 16'h00FF;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_CRC16 = 2'd1;
  localparam logic [1:0] MODE_SUM8  = 2'd2;
  localparam logic [1:0] MODE_SUM16 = 2'd3;

  localparam logic REG_CHECK_MODE    = 1'b0;
  localparam logic REG_LITTLE_ENDIAN = 1'b1;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic [15:0] received_code;
    logic        last_byte;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic        match;
    logic [15:0] wire_code;
    logic [15:0] check_value;
  } result_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fcce_in_stage.sv =====
// Input register of the frame check code engine.
// Depends on fcce_pkg.
`default_nettype none

module fcce_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire logic           drain,
  input  wire fcce_pkg::item_t item_in,
  output logic                valid,
  output fcce_pkg::item_t     item
);
  import fcce_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (drain) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fcce_accum.sv =====
// CRC-16 and byte-sum accumulators with result selection.
// Depends on fcce_pkg.
`default_nettype none

module fcce_accum (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire fcce_pkg::item_t item,
  input  wire logic [1:0]      check_mode,
  input  wire logic            little_endian,
  output fcce_pkg::result_t    result
);
  import fcce_pkg::*;

  logic [15:0] crc_acc;
  logic [15:0] sum_acc;
  logic [15:0] crc_next;
  logic [15:0] sum_next;
  logic [15:0] value;

  assign crc_next = crc_update(crc_acc, item.data_byte);
  assign sum_next = sum_acc + {8'h00, item.data_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc <= CRC_INIT;
      sum_acc <= 16'h0000;
    end else if (step) begin
      if (item.last_byte) begin
        crc_acc <= CRC_INIT;
        sum_acc <= 16'h0000;
      end else begin
        crc_acc <= crc_next;
        sum_acc <= sum_next;
      end
    end
  end

  always_comb begin
    value = 16'h0000;
    result = '0;
    case (check_mode)
      MODE_CRC16, MODE_SUM16: begin
        value = (check_mode == MODE_CRC16) ? crc_next : sum_next;
        result.check_value = value;
        result.wire_code = little_endian ? value : {value[7:0], value[15:8]};
        result.match = (result.wire_code == item.received_code);
      end
      MODE_SUM8: begin
        value = sum_next & BYTE_MASK;
        result.check_value = value;
        result.wire_code = value;
        result.match = (value[7:0] == item.received_code[7:0]);
      end
      default: begin
        result.check_value = 16'h0000;
        result.wire_code = 16'h0000;
        result.match = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/fcce_out_stage.sv =====
// Result register of the frame check code engine, held while the receiver stalls.
// Depends on fcce_pkg.
`default_nettype none

module fcce_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire fcce_pkg::result_t result_in,
  input  wire logic              ready,
  output logic                   valid,
  output fcce_pkg::result_t      result
);
  import fcce_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/frame_check_code_engine.sv =====
// Frame check code engine: CRC-16 (reflected, 0xA001), sum8 or sum16 over a byte stream.
// Depends on fcce_pkg, fcce_in_stage, fcce_accum, fcce_out_stage and the macros header.
//
// Usage:
//   Slave channel carries one covered byte per transaction; s_tlast marks the
//   final covered byte, whose transaction also carries the received check code.
//   Master channel carries one result per frame, issued for the final byte only.
//   A final byte is held in the input register, then its result in the output register.
//   Throughput: one byte per cycle outside stalls; the CRC update is an unrolled
//   8-bit step between the input register and the accumulator, so it sets the cycle.
//   Stall: a waiting result holds in the output register; non-final bytes keep
//   flowing, and a final byte waits in the input register until the output
//   register is free, which then backs up s_tready.
//   Reset (rst, synchronous): both stages empty, CRC reloads 0xFFFF, sum
//   reloads 0, check_mode is none and little_endian is 1.
//   Configuration: cfg_we writes cfg_data to register cfg_index
//   (0 check_mode, 1 little_endian); write only while the block is idle.
//   The mode in force when the final byte is processed selects the result.
`default_nettype none
`include "frame_check_code_engine_macros.svh"

module frame_check_code_engine (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [1:0]                        cfg_data,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // data_byte[7:0], received_code[23:8]
  input  wire logic [fcce_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  wire logic                              s_tlast,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // check_value[15:0], wire_code[31:16], match[32], zero[39:33]
  output logic [fcce_pkg::OUT_TDATA_W-1:0]       m_tdata
);
  import fcce_pkg::*;

  logic [1:0] check_mode;
  logic       little_endian;
  item_t      item_in;
  item_t      item;
  logic       in_valid;
  logic       out_room;
  logic       step;
  logic       emit;
  logic       s_fire;
  result_t    result_c;
  result_t    result_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode    <= MODE_NONE;
      little_endian <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHECK_MODE:    check_mode    <= cfg_data;
        REG_LITTLE_ENDIAN: little_endian <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign item_in.data_byte     = s_tdata[7:0];
  assign item_in.received_code = s_tdata[23:8];
  assign item_in.last_byte     = s_tlast;

  assign out_room = !m_tvalid || m_tready;
  assign step     = in_valid && (!item.last_byte || out_room);
  assign emit     = step && item.last_byte;
  assign s_tready = !in_valid || step;
  assign s_fire   = s_tvalid && s_tready;

  fcce_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .load    (s_fire),
    .drain   (step),
    .item_in (item_in),
    .valid   (in_valid),
    .item    (item)
  );

  fcce_accum u_accum (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .item          (item),
    .check_mode    (check_mode),
    .little_endian (little_endian),
    .result        (result_c)
  );

  fcce_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .result_in (result_c),
    .ready     (m_tready),
    .valid     (m_tvalid),
    .result    (result_q)
  );

  assign m_tdata = {7'b0000000, result_q.match, result_q.wire_code, result_q.check_value};

  `FCCE_ASSERT_ALWAYS(a_empty_after_reset, clk, $past(rst) |-> (!m_tvalid && !in_valid), "result or byte pending right after reset")
  `FCCE_ASSERT(a_no_result_for_inner_byte, clk, rst, (step && !item.last_byte && out_room) |=> !m_tvalid, "result produced for a non-final byte")
  `FCCE_ASSERT(a_mode_none_result, clk, rst, (m_tvalid && check_mode == MODE_NONE) |-> (result_q.match && result_q.check_value == 16'h0000 && result_q.wire_code == 16'h0000), "mode none result is not a zero match")
  `FCCE_ASSERT(a_sum8_upper_zero, clk, rst, (m_tvalid && check_mode == MODE_SUM8) |-> (result_q.check_value[15:8] == 8'h00 && result_q.wire_code == result_q.check_value), "sum8 result has upper byte set")

endmodule

`default_nettype wire

// ===== sim/fcce_checker.sv =====
// Checker for the frame check code engine: watches the config port and both streams,
// predicts each frame's check result and compares it with the master channel.
// Depends on fcce_pkg for the mode and register codes and the result layout.
`default_nettype none

module fcce_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [23:0] s_tdata,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [39:0] m_tdata,
  output int               fail_count,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import fcce_pkg::*;

  result_t     expected_codes[$];
  logic [1:0]  mode_q = MODE_NONE;
  logic        le_q = 1'b1;
  logic [15:0] crc_q = CRC_INIT;
  logic [15:0] sum_q = 16'h0000;
  int          mismatches = 0;
  int          pending_n = 0;

  assign fail_count  = mismatches;
  assign outstanding = pending_n;

  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic result_t close_frame(input logic [1:0] mode, input logic le,
                                          input logic [15:0] crc, input logic [15:0] sum,
                                          input logic [15:0] rx);
    result_t r;
    r.check_value = 16'h0000;
    r.wire_code   = 16'h0000;
    r.match       = 1'b1;
    case (mode)
      MODE_CRC16, MODE_SUM16: begin
        r.check_value = (mode == MODE_CRC16) ? crc : sum;
        r.wire_code   = le ? r.check_value : {r.check_value[7:0], r.check_value[15:8]};
        r.match       = (r.wire_code == rx);
      end
      MODE_SUM8: begin
        r.check_value = {8'h00, sum[7:0]};
        r.wire_code   = r.check_value;
        r.match       = (sum[7:0] == rx[7:0]);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    logic [15:0] crc_n;
    logic [15:0] sum_n;
    result_t     got;
    result_t     want;
    if (rst) begin
      mode_q <= MODE_NONE;
      le_q   <= 1'b1;
      crc_q  <= CRC_INIT;
      sum_q  <= 16'h0000;
      expected_codes.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[32:0]);
        if (expected_codes.size() == 0) begin
          report_mismatch("result with no frame pending", got.check_value, 16'h0000);
        end else begin
          want = expected_codes.pop_front();
          if (got.check_value !== want.check_value)
            report_mismatch("check_value", got.check_value, want.check_value);
          if (got.wire_code !== want.wire_code)
            report_mismatch("wire_code", got.wire_code, want.wire_code);
          if (got.match !== want.match)
            report_mismatch("match", {15'h0, got.match}, {15'h0, want.match});
          if (m_tdata[39:33] !== 7'h00)
            report_mismatch("tdata padding", {9'h0, m_tdata[39:33]}, 16'h0000);
        end
      end
      if (s_tvalid && s_tready) begin
        crc_n = crc_step(crc_q, s_tdata[7:0]);
        sum_n = sum_q + {8'h00, s_tdata[7:0]};
        if (s_tlast) begin
          expected_codes.push_back(close_frame(mode_q, le_q, crc_n, sum_n, s_tdata[23:8]));
          crc_q <= CRC_INIT;
          sum_q <= 16'h0000;
        end else begin
          crc_q <= crc_n;
          sum_q <= sum_n;
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_CHECK_MODE) begin
          mode_q <= cfg_data;
        end else begin
          le_q <= cfg_data[0];
        end
      end
    end
    pending_n = expected_codes.size();
  end

endmodule

`default_nettype wire

// ===== sim/tb_frame_check_code_engine.sv =====
// Testbench top for the frame check code engine: clock, reset, config writes, frame
// stimulus with random gaps and back-pressure, and the final verdict.
// Depends on fcce_pkg, frame_check_code_engine and fcce_checker.
`default_nettype none

module tb_frame_check_code_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import fcce_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_CHECK_MODE;
  logic [1:0]  cfg_data = 2'd0;
  logic        s_tvalid = 1'b0;
  logic [23:0] s_tdata = 24'h0;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  wire logic        s_tready;
  wire logic        m_tvalid;
  wire logic [39:0] m_tdata;
  int          fail_count;
  int          outstanding;

  logic [1:0]  stim_mode = MODE_NONE;
  logic        stim_le = 1'b1;
  bit          quiet = 1'b0;
  bit          long_hold_req = 1'b0;
  logic [7:0]  frame_buf[$];

  always #1 clk = ~clk;

  frame_check_code_engine DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  fcce_checker CHK (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // code a well-behaved sender would append to frame_buf under the current setting
  function automatic logic [15:0] frame_wire_code();
    logic [15:0] crc;
    logic [15:0] sum;
    logic [15:0] v;
    crc = CRC_INIT;
    sum = 16'h0000;
    foreach (frame_buf[i]) begin
      crc = crc ^ {8'h00, frame_buf[i]};
      repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      sum = sum + {8'h00, frame_buf[i]};
    end
    case (stim_mode)
      MODE_CRC16: v = crc;
      MODE_SUM16: v = sum;
      MODE_SUM8:  return {8'h00, sum[7:0]};
      default:    return 16'h0000;
    endcase
    return stim_le ? v : {v[7:0], v[15:8]};
  endfunction

  task automatic push_byte(input logic [7:0] d, input logic last, input logic [15:0] rx);
    int n;
    n = gap_len();
    if (n > 0) begin
      s_tvalid = 1'b0;
      repeat (n) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {rx, d};
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_frame(input bit force_good);
    logic [15:0] good;
    logic [15:0] rx;
    int          k;
    good = frame_wire_code();
    k = force_good ? 0 : $urandom_range(0, 9);
    if (k < 5) begin
      rx = good;
      if (stim_mode == MODE_SUM8) rx[15:8] = 8'($urandom_range(0, 255));
    end else if (k < 7) begin
      rx = good ^ (16'h1 << $urandom_range(0, 15));
    end else if (k < 8) begin
      rx = {good[7:0], good[15:8]};
    end else begin
      rx = 16'($urandom_range(0, 65535));
    end
    foreach (frame_buf[i]) begin
      if (i == frame_buf.size() - 1) begin
        push_byte(frame_buf[i], 1'b1, rx);
      end else begin
        push_byte(frame_buf[i], 1'b0, 16'($urandom_range(0, 65535)));
      end
    end
  endtask

  task automatic settle();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_cfg(input logic [1:0] mode, input logic le);
    settle();
    cfg_write(REG_CHECK_MODE, mode);
    cfg_write(REG_LITTLE_ENDIAN, {1'($urandom_range(0, 1)), le});
    stim_mode = mode;
    stim_le   = le;
  endtask

  initial begin : sink
    int n;
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready = 1'b0;
        repeat (400) @(negedge clk);
      end
      m_tready = 1'b1;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      n = gap_len();
      if (n > 0) begin
        m_tready = 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int sent;
    int len;
    int r;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset setting is mode none, little endian
    frame_buf = '{8'hFF};
    send_frame(1'b0);
    set_cfg(MODE_CRC16, 1'b1);
    frame_buf = '{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h01};
    send_frame(1'b1);
    frame_buf = '{8'hFF};
    send_frame(1'b1);
    frame_buf = '{8'h00};
    push_byte(8'h00, 1'b1, 16'hFFFF);
    set_cfg(MODE_SUM16, 1'b0);
    frame_buf = '{8'hFF, 8'hFF, 8'hFF};
    send_frame(1'b1);
    set_cfg(MODE_SUM8, 1'b1);
    frame_buf = '{8'hFF, 8'hFF};
    send_frame(1'b1);
    set_cfg(MODE_SUM8, 1'b0);
    frame_buf = '{8'h80, 8'h80};
    send_frame(1'b1);
    set_cfg(MODE_NONE, 1'b0);
    frame_buf = '{8'h55};
    push_byte(8'h55, 1'b1, 16'hA5A5);
    // mode switched between bytes of one frame
    set_cfg(MODE_CRC16, 1'b1);
    frame_buf = '{8'h12, 8'h34, 8'h56};
    push_byte(8'h12, 1'b0, 16'h0000);
    push_byte(8'h34, 1'b0, 16'hFFFF);
    set_cfg(MODE_SUM16, 1'b1);
    push_byte(8'h56, 1'b1, frame_wire_code());

    for (int p = 0; p < 12; p++) begin
      if (p < 8) begin
        set_cfg(2'(p), 1'(p >> 2));
      end else begin
        set_cfg(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
      quiet = (p == 9);
      if (p == 10) begin
        // sink stalls for a long stretch while single-byte frames keep coming
        quiet = 1'b1;
        long_hold_req = 1'b1;
        for (int f = 0; f < 40; f++) begin
          frame_buf = '{8'($urandom_range(0, 255))};
          send_frame(1'b0);
        end
        quiet = 1'b0;
      end
      sent = 0;
      while (sent < 100) begin
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(1, 6);
        else if (r < 95) len = $urandom_range(7, 20);
        else len = $urandom_range(21, 64);
        frame_buf.delete();
        repeat (len) frame_buf.push_back(8'($urandom_range(0, 255)));
        send_frame(1'b0);
        sent += len;
      end
    end
    quiet = 1'b0;

    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/fcce_pkg.sv
rtl/fcce_in_stage.sv
rtl/fcce_accum.sv
rtl/fcce_out_stage.sv
rtl/frame_check_code_engine.sv
sim/fcce_checker.sv
sim/tb_frame_check_code_engine.sv
